>>> rtl/ppm_pkg.sv
package ppm_pkg;

    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int CHANNEL_BITS_DEF = 8;
    localparam int SEL_BITS         = 5;
    localparam int FRAC_W           = 17;
    localparam int DEN_W            = 27;
    localparam int NUM_W            = 30;
    localparam int RESET_HIGH       = 32767;
    localparam int NUM_RAMPS        = 21;

    localparam logic [1:0] CFG_RANGE_LOW   = 2'd0;
    localparam logic [1:0] CFG_RANGE_HIGH  = 2'd1;
    localparam logic [1:0] CFG_RAMP_SELECT = 2'd2;

    localparam logic [4:0] RAMP_WHITE         = 5'd0;
    localparam logic [4:0] RAMP_JET           = 5'd1;
    localparam logic [4:0] RAMP_BLUE_RED      = 5'd2;
    localparam logic [4:0] RAMP_GREY          = 5'd3;
    localparam logic [4:0] RAMP_HUE           = 5'd4;
    localparam logic [4:0] RAMP_GREEN_YELLOW  = 5'd5;
    localparam logic [4:0] RAMP_GREEN_MAGENTA = 5'd6;
    localparam logic [4:0] RAMP_WALK          = 5'd7;
    localparam logic [4:0] RAMP_GREY_PEAK     = 5'd8;
    localparam logic [4:0] RAMP_THREE_SEG     = 5'd9;
    localparam logic [4:0] RAMP_FIVE_SEG      = 5'd10;
    localparam logic [4:0] RAMP_BLEND_TWO     = 5'd11;
    localparam logic [4:0] RAMP_BLEND_A       = 5'd12;
    localparam logic [4:0] RAMP_BLEND_B       = 5'd13;
    localparam logic [4:0] RAMP_YELLOW_RED    = 5'd14;
    localparam logic [4:0] RAMP_TO_WHITE      = 5'd15;
    localparam logic [4:0] RAMP_TWO_A         = 5'd16;
    localparam logic [4:0] RAMP_TWO_B         = 5'd17;
    localparam logic [4:0] RAMP_BLUE_CYAN     = 5'd18;
    localparam logic [4:0] RAMP_BLUE_WHITE    = 5'd19;
    localparam logic [4:0] RAMP_BLEND_C       = 5'd20;

    typedef logic [7:0] t_c8;

    typedef struct packed {
        t_c8 r;
        t_c8 g;
        t_c8 b;
    } t_rgb8;

    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
    } t_frac;

    function automatic logic [4:0] ramp_mod(input logic [4:0] s);
        ramp_mod = (s >= 5'(NUM_RAMPS)) ? 5'(s - 5'(NUM_RAMPS)) : s;
    endfunction

    function automatic logic [2:0] seg_count(input logic [4:0] mode);
        logic [2:0] n;
        n = 3'd1;
        unique case (mode)
            RAMP_JET, RAMP_WALK, RAMP_TO_WHITE:       n = 3'd4;
            RAMP_HUE:                                 n = 3'd6;
            RAMP_GREY_PEAK, RAMP_TWO_A, RAMP_TWO_B:   n = 3'd2;
            RAMP_THREE_SEG:                           n = 3'd3;
            RAMP_FIVE_SEG:                            n = 3'd5;
            default:                                  n = 3'd1;
        endcase
        return n;
    endfunction

    // Blend colors in units of 1/255; idx picks the first, middle or last color.
    function automatic t_rgb8 blend_color(input logic [4:0] mode, input logic [1:0] idx);
        t_rgb8 c;
        c = '{r: 8'd0, g: 8'd0, b: 8'd0};
        unique case (mode)
            RAMP_BLEND_TWO: begin
                if (idx == 2'd0) c = '{r: 8'd200, g: 8'd60, b: 8'd0};
                else             c = '{r: 8'd250, g: 8'd160, b: 8'd110};
            end
            RAMP_BLEND_A: begin
                if (idx == 2'd0)      c = '{r: 8'd55, g: 8'd55, b: 8'd45};
                else if (idx == 2'd1) c = '{r: 8'd200, g: 8'd60, b: 8'd0};
                else                  c = '{r: 8'd250, g: 8'd160, b: 8'd110};
            end
            RAMP_BLEND_B: begin
                if (idx == 2'd0)      c = '{r: 8'd0, g: 8'd255, b: 8'd0};
                else if (idx == 2'd1) c = '{r: 8'd255, g: 8'd150, b: 8'd0};
                else                  c = '{r: 8'd255, g: 8'd250, b: 8'd240};
            end
            RAMP_BLEND_C: begin
                if (idx == 2'd0)      c = '{r: 8'd0, g: 8'd160, b: 8'd0};
                else if (idx == 2'd1) c = '{r: 8'd180, g: 8'd220, b: 8'd0};
                else                  c = '{r: 8'd250, g: 8'd220, b: 8'd170};
            end
            default: c = '{r: 8'd0, g: 8'd0, b: 8'd0};
        endcase
        return c;
    endfunction

endpackage

>>> rtl/ppm_norm.sv
module ppm_norm #(
    parameter int SAMPLE_BITS = ppm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    input  logic [SAMPLE_BITS-1:0]          i_lo,
    input  logic [SAMPLE_BITS-1:0]          i_hi,
    output logic                            o_valid,
    output logic [ppm_pkg::FRAC_W-1:0]      o_frac
);
    import ppm_pkg::*;

    localparam int SB = SAMPLE_BITS;

    logic                 r_v   [0:FRAC_W];
    logic                 r_e   [0:FRAC_W];
    logic [SB-1:0]        r_rem [0:FRAC_W-1];
    logic [SB-1:0]        r_d   [0:FRAC_W-1];
    logic [FRAC_W-1:0]    r_q   [1:FRAC_W];

    logic signed [SB-1:0] lo_s, hi_s, v_s, vc_s;
    logic                 empty;
    logic [SB-1:0]        n_rem0, n_d0;

    always_comb begin
        lo_s  = $signed(i_lo);
        hi_s  = $signed(i_hi);
        v_s   = $signed(i_sample);
        empty = !(hi_s > lo_s);
        vc_s  = v_s;
        if (v_s < lo_s) vc_s = lo_s;
        if (v_s > hi_s) vc_s = hi_s;
        n_rem0 = SB'({vc_s[SB-1], vc_s} - {lo_s[SB-1], lo_s});
        n_d0   = SB'({hi_s[SB-1], hi_s} - {lo_s[SB-1], lo_s});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e[0]   <= empty;
            r_rem[0] <= n_rem0;
            r_d[0]   <= n_d0;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 0; j < FRAC_W; j++) begin : g_stage
        logic [SB:0]       trial;
        logic [SB:0]       diff;
        logic              ge;
        logic [FRAC_W-1:0] q_in;

        if (j == 0) begin : g_first
            assign trial = {1'b0, r_rem[0]};
            assign q_in  = '0;
        end else begin : g_next
            assign trial = {r_rem[j], 1'b0};
            assign q_in  = r_q[j];
        end

        assign ge   = trial >= {1'b0, r_d[j]};
        assign diff = trial - {1'b0, r_d[j]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_e[j+1] <= r_e[j];
                r_q[j+1] <= {q_in[FRAC_W-2:0], ge};
            end
        end

        if (j < FRAC_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j+1] <= ge ? diff[SB-1:0] : trial[SB-1:0];
                    r_d[j+1]   <= r_d[j];
                end
            end
        end
    end

    assign o_valid = r_v[FRAC_W];
    assign o_frac  = r_e[FRAC_W] ? '0 : r_q[FRAC_W];

endmodule

>>> rtl/ppm_ramp.sv
module ppm_ramp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [ppm_pkg::FRAC_W-1:0]    i_frac,
    input  logic [4:0]                    i_sel,
    output logic                          o_valid,
    output ppm_pkg::t_frac [2:0]          o_frac
);
    import ppm_pkg::*;

    localparam logic [16:0] FONE = 17'h10000;

    logic [19:0]  s;
    logic [2:0]   n;
    logic [3:0]   kraw;
    logic [2:0]   k;
    logic [16:0]  l, nl, u, f;
    logic [16:0]  c_r, c_g, c_b;
    logic [19:0]  f10, thr, dd;
    logic [2:0]   rten, m;
    logic         first, blended;
    t_rgb8        c1, c2;
    logic [10:0]  mden;

    logic [2:0][DEN_W-1:0] n_base;
    logic [2:0][8:0]       n_delta;
    logic [DEN_W-1:0]      n_den;
    logic [19:0]           n_d;

    logic                  r1_v;
    logic [2:0][DEN_W-1:0] r1_base;
    logic [2:0][8:0]       r1_delta;
    logic [DEN_W-1:0]      r1_den;
    logic [19:0]           r1_d;

    logic                  r2_v;
    t_frac [2:0]           r2_frac;
    t_frac [2:0]           n_frac;

    always_comb begin
        f    = i_frac;
        u    = FONE - f;
        n    = seg_count(i_sel);
        s    = 20'(f) * 20'(n);
        kraw = s[19:16];
        k    = (kraw >= {1'b0, n}) ? 3'(n - 3'd1) : kraw[2:0];
        l    = 17'(s - {1'b0, k, 16'h0});
        nl   = FONE - l;

        c_r = FONE;
        c_g = FONE;
        c_b = FONE;
        unique case (i_sel)
            RAMP_JET: begin
                if (k == 3'd0)      begin c_r = '0;   c_g = l;    c_b = FONE; end
                else if (k == 3'd1) begin c_r = '0;   c_g = FONE; c_b = nl;   end
                else if (k == 3'd2) begin c_r = l;    c_g = FONE; c_b = '0;   end
                else                begin c_r = FONE; c_g = nl;   c_b = '0;   end
            end
            RAMP_BLUE_RED:      begin c_r = f; c_g = '0; c_b = u; end
            RAMP_GREY:          begin c_r = f; c_g = f;  c_b = f; end
            RAMP_HUE: begin
                if (k == 3'd0)      begin c_r = FONE; c_g = l;    c_b = '0;   end
                else if (k == 3'd1) begin c_r = nl;   c_g = FONE; c_b = '0;   end
                else if (k == 3'd2) begin c_r = '0;   c_g = FONE; c_b = l;    end
                else if (k == 3'd3) begin c_r = '0;   c_g = nl;   c_b = FONE; end
                else if (k == 3'd4) begin c_r = l;    c_g = '0;   c_b = FONE; end
                else                begin c_r = FONE; c_g = '0;   c_b = nl;   end
            end
            RAMP_GREEN_YELLOW:  begin c_r = f; c_g = FONE; c_b = '0; end
            RAMP_GREEN_MAGENTA: begin c_r = f; c_g = u;    c_b = f;  end
            RAMP_WALK: begin
                if (k == 3'd0)      begin c_r = '0; c_g = l;  c_b = nl; end
                else if (k == 3'd1) begin c_r = l;  c_g = nl; c_b = '0; end
                else if (k == 3'd2) begin c_r = nl; c_g = l;  c_b = '0; end
                else                begin c_r = '0; c_g = nl; c_b = l;  end
            end
            RAMP_GREY_PEAK: begin
                if (k == 3'd0) begin c_r = l;  c_g = l;  c_b = l;  end
                else           begin c_r = nl; c_g = nl; c_b = nl; end
            end
            RAMP_THREE_SEG: begin
                if (k == 3'd0)      begin c_r = nl; c_g = '0; c_b = l;    end
                else if (k == 3'd1) begin c_r = '0; c_g = l;  c_b = FONE; end
                else                begin c_r = l;  c_g = nl; c_b = FONE; end
            end
            RAMP_FIVE_SEG: begin
                if (k == 3'd0)      begin c_r = '0;   c_g = l;    c_b = FONE; end
                else if (k == 3'd1) begin c_r = '0;   c_g = FONE; c_b = nl;   end
                else if (k == 3'd2) begin c_r = l;    c_g = FONE; c_b = '0;   end
                else if (k == 3'd3) begin c_r = FONE; c_g = nl;   c_b = '0;   end
                else                begin c_r = FONE; c_g = l;    c_b = l;    end
            end
            RAMP_YELLOW_RED:    begin c_r = FONE; c_g = u; c_b = '0; end
            RAMP_TO_WHITE: begin
                if (k == 3'd0)      begin c_r = '0;   c_g = l;    c_b = FONE; end
                else if (k == 3'd1) begin c_r = '0;   c_g = FONE; c_b = nl;   end
                else if (k == 3'd2) begin c_r = l;    c_g = FONE; c_b = '0;   end
                else                begin c_r = FONE; c_g = FONE; c_b = l;    end
            end
            RAMP_TWO_A: begin
                if (k == 3'd0) begin c_r = '0; c_g = l;  c_b = nl; end
                else           begin c_r = l;  c_g = nl; c_b = '0; end
            end
            RAMP_TWO_B: begin
                if (k == 3'd0) begin c_r = FONE; c_g = nl; c_b = l;    end
                else           begin c_r = nl;   c_g = l;  c_b = FONE; end
            end
            RAMP_BLUE_CYAN:     begin c_r = '0; c_g = f; c_b = FONE; end
            RAMP_BLUE_WHITE:    begin c_r = f;  c_g = f; c_b = FONE; end
            default:            begin c_r = FONE; c_g = FONE; c_b = FONE; end
        endcase

        // Blends: num = c1 * m * 2^16 + (c2 - c1) * d over den = 255 * m * 2^16.
        blended = (i_sel == RAMP_BLEND_TWO) || (i_sel == RAMP_BLEND_A) ||
                  (i_sel == RAMP_BLEND_B) || (i_sel == RAMP_BLEND_C);
        rten  = (i_sel == RAMP_BLEND_A) ? 3'd4 : 3'd3;
        f10   = 20'(f) * 20'd10;
        thr   = {1'b0, rten, 16'h0};
        first = f10 < thr;
        if (i_sel == RAMP_BLEND_TWO) begin
            c1 = blend_color(i_sel, 2'd0);
            c2 = blend_color(i_sel, 2'd1);
            m  = 3'd1;
            dd = 20'(f);
        end else if (first) begin
            c1 = blend_color(i_sel, 2'd0);
            c2 = blend_color(i_sel, 2'd1);
            m  = rten;
            dd = f10;
        end else begin
            c1 = blend_color(i_sel, 2'd1);
            c2 = blend_color(i_sel, 2'd2);
            m  = 3'(4'd10 - {1'b0, rten});
            dd = f10 - thr;
        end
        mden = 11'(8'd255) * 11'(m);

        if (blended) begin
            n_base[0]  = {11'(c1.r) * 11'(m), 16'h0};
            n_base[1]  = {11'(c1.g) * 11'(m), 16'h0};
            n_base[2]  = {11'(c1.b) * 11'(m), 16'h0};
            n_delta[0] = {1'b0, c2.r} - {1'b0, c1.r};
            n_delta[1] = {1'b0, c2.g} - {1'b0, c1.g};
            n_delta[2] = {1'b0, c2.b} - {1'b0, c1.b};
            n_d        = dd;
            n_den      = {mden, 16'h0};
        end else begin
            n_base[0]  = DEN_W'(c_r);
            n_base[1]  = DEN_W'(c_g);
            n_base[2]  = DEN_W'(c_b);
            n_delta    = '0;
            n_d        = '0;
            n_den      = DEN_W'(FONE);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_frac[i].num = $signed({{(NUM_W-DEN_W){1'b0}}, r1_base[i]}) +
                            $signed({{(NUM_W-9){r1_delta[i][8]}}, r1_delta[i]}) *
                            $signed({{(NUM_W-20){1'b0}}, r1_d});
            n_frac[i].den = r1_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_base  <= n_base;
            r1_delta <= n_delta;
            r1_d     <= n_d;
            r1_den   <= n_den;
            r2_frac  <= n_frac;
        end
    end

    assign o_valid = r2_v;
    assign o_frac  = r2_frac;

endmodule

>>> rtl/ppm_chdiv.sv
module ppm_chdiv #(
    parameter int CHANNEL_BITS = ppm_pkg::CHANNEL_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  ppm_pkg::t_frac          i_frac,
    output logic                    o_valid,
    output logic [CHANNEL_BITS-1:0] o_chan
);
    import ppm_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam int NW = DEN_W + CB;

    logic [DEN_W-1:0] nc;
    logic [NW-1:0]    n_dvd;

    logic             r_v   [0:CB];
    logic [DEN_W-1:0] r_rem [0:CB-1];
    logic [CB-1:0]    r_low [0:CB-1];
    logic [DEN_W-1:0] r_den [0:CB-1];
    logic [CB-1:0]    r_q   [1:CB];

    // Clamp to [0, den], then form num * (2^CB - 1) + den / 2.
    always_comb begin
        if (i_frac.num < 0) begin
            nc = '0;
        end else if (i_frac.num > $signed({{(NUM_W-DEN_W){1'b0}}, i_frac.den})) begin
            nc = i_frac.den;
        end else begin
            nc = i_frac.num[DEN_W-1:0];
        end
        n_dvd = {nc, {CB{1'b0}}} - NW'(nc) + NW'(i_frac.den >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_dvd[NW-1:CB];
            r_low[0] <= n_dvd[CB-1:0];
            r_den[0] <= i_frac.den;
        end
    end

    for (genvar j = 0; j < CB; j++) begin : g_stage
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;
        logic [CB-1:0]  q_in;

        if (j == 0) begin : g_first
            assign q_in = '0;
        end else begin : g_next
            assign q_in = r_q[j];
        end

        assign trial = {r_rem[j], r_low[j][CB-1]};
        assign ge    = trial >= {1'b0, r_den[j]};
        assign diff  = trial - {1'b0, r_den[j]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        if (CB == 1) begin : g_q1
            always_ff @(posedge i_clk) begin
                if (i_en) r_q[j+1] <= ge;
            end
        end else begin : g_qn
            always_ff @(posedge i_clk) begin
                if (i_en) r_q[j+1] <= {q_in[CB-2:0], ge};
            end
        end

        if (j < CB - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    r_low[j+1] <= r_low[j] << 1;
                    r_den[j+1] <= r_den[j];
                end
            end
        end
    end

    assign o_valid = r_v[CB];
    assign o_chan  = r_q[CB];

endmodule

>>> rtl/pseudocolor_ramp_mapper.sv
// Pseudocolor ramp mapper: one signed sample in, one RGB color out.
// Input channel: i_valid / o_stall with i_sample; an item is taken on a clock
// edge where i_valid is high and o_stall is low. Output channel: o_valid /
// i_stall with o_red, o_green, o_blue; an item leaves where o_valid is high
// and i_stall is low.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index
// (0 range_low, 1 range_high, 2 ramp_select); write only while idle.
// Throughput is one item per clock unless the receiver stalls. The pipeline has
// one input stage, 17 stages of the restoring divider that forms the Q1.16 fraction,
// two ramp stages (segment/blend select, then the multiply-add), one rounding
// setup stage and one stage per output bit of the per-channel rounding divider.
// Reset clears all valid bits and loads range 0..32767 with ramp 1.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_stall rises; nothing is dropped or repeated.
module pseudocolor_ramp_mapper #(
    parameter int SAMPLE_BITS  = ppm_pkg::SAMPLE_BITS_DEF,
    parameter int CHANNEL_BITS = ppm_pkg::CHANNEL_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [SAMPLE_BITS-1:0]   i_sample,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [CHANNEL_BITS-1:0]  o_red,
    output logic [CHANNEL_BITS-1:0]  o_green,
    output logic [CHANNEL_BITS-1:0]  o_blue,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [((SAMPLE_BITS > ppm_pkg::SEL_BITS) ? SAMPLE_BITS : ppm_pkg::SEL_BITS)-1:0]
                                     i_cfg_wdata
);
    import ppm_pkg::*;

    logic [SAMPLE_BITS-1:0] r_lo, r_hi;
    logic [SEL_BITS-1:0]    r_sel;
    logic                   en;
    logic                   norm_v, ramp_v;
    logic [FRAC_W-1:0]      frac;
    t_frac [2:0]            ramp_frac;
    logic [2:0]             ch_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo  <= '0;
            r_hi  <= SAMPLE_BITS'(RESET_HIGH);
            r_sel <= RAMP_JET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RANGE_LOW:   r_lo  <= i_cfg_wdata[SAMPLE_BITS-1:0];
                CFG_RANGE_HIGH:  r_hi  <= i_cfg_wdata[SAMPLE_BITS-1:0];
                CFG_RAMP_SELECT: r_sel <= i_cfg_wdata[SEL_BITS-1:0];
                default:         ;
            endcase
        end
    end

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    ppm_norm #(.SAMPLE_BITS(SAMPLE_BITS)) u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_sample (i_sample),
        .i_lo     (r_lo),
        .i_hi     (r_hi),
        .o_valid  (norm_v),
        .o_frac   (frac)
    );

    ppm_ramp u_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (norm_v),
        .i_frac  (frac),
        .i_sel   (ramp_mod(r_sel)),
        .o_valid (ramp_v),
        .o_frac  (ramp_frac)
    );

    ppm_chdiv #(.CHANNEL_BITS(CHANNEL_BITS)) u_div_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ramp_v),
        .i_frac  (ramp_frac[0]),
        .o_valid (ch_v[0]),
        .o_chan  (o_red)
    );

    ppm_chdiv #(.CHANNEL_BITS(CHANNEL_BITS)) u_div_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ramp_v),
        .i_frac  (ramp_frac[1]),
        .o_valid (ch_v[1]),
        .o_chan  (o_green)
    );

    ppm_chdiv #(.CHANNEL_BITS(CHANNEL_BITS)) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ramp_v),
        .i_frac  (ramp_frac[2]),
        .o_valid (ch_v[2]),
        .o_chan  (o_blue)
    );

    // All three channel dividers advance together, so their valid bits agree.
    assign o_valid = ch_v[0] & ch_v[1] & ch_v[2];

endmodule

>>> sim/pseudocolor_ramp_mapper_test.sv
`timescale 1ns / 100ps

module pseudocolor_ramp_mapper_test;
    import ppm_pkg::*;

    localparam int FONE = 65536;
    localparam int LATENCY = 29;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    // Scoreboard: holds the register copy and the colors still owed by the block.
    class color_scoreboard;
        logic signed [15:0] lo_reg;
        logic signed [15:0] hi_reg;
        logic [4:0]         sel_reg;
        t_color             pending[$];
        int                 errors;

        function new();
            lo_reg = 16'sd0;
            hi_reg = 16'sd32767;
            sel_reg = RAMP_JET;
            errors = 0;
        endfunction

        function logic [7:0] to_chan(longint num, longint den);
            if (num < 0) num = 0;
            if (num > den) num = den;
            return 8'((num * 255 + den / 2) / den);
        endfunction

        function int seg_of(longint f, int n, output longint loc);
            longint k;
            k = (f * n) >>> 16;
            if (k > n - 1) k = n - 1;
            loc = f * n - k * FONE;
            return int'(k);
        endfunction

        function void put_rgb(ref longint c[3], input longint r, longint g, longint b);
            c[0] = r; c[1] = g; c[2] = b;
        endfunction

        // Three-color blend; rten is the break point times ten.
        function void blend(longint a[3], longint b[3], longint d[3], longint rten,
                            longint f, ref longint num[3], ref longint den[3]);
            longint q;
            q = 10 - rten;
            for (int i = 0; i < 3; i++) begin
                if (f * 10 < rten * FONE) begin
                    num[i] = a[i] * rten * FONE + (b[i] - a[i]) * f * 10;
                    den[i] = 255 * rten * FONE;
                end else begin
                    num[i] = b[i] * q * FONE + (d[i] - b[i]) * (f * 10 - rten * FONE);
                    den[i] = 255 * q * FONE;
                end
            end
        endfunction

        function t_color map_sample(logic signed [15:0] smp);
            longint v, lo, hi, f, u, l;
            longint c[3], num[3], den[3];
            int k;
            logic [4:0] mode;
            bit mixed;
            t_color res;
            lo = lo_reg; hi = hi_reg; v = smp; f = 0; l = 0; mixed = 0;
            mode = 5'(sel_reg % 5'd21);
            if (hi > lo) begin
                if (v < lo) v = lo;
                if (v > hi) v = hi;
                f = ((v - lo) << 16) / (hi - lo);
            end
            u = FONE - f;
            put_rgb(c, FONE, FONE, FONE);
            case (mode)
                RAMP_JET: begin
                    k = seg_of(f, 4, l);
                    if (k == 0) put_rgb(c, 0, l, FONE);
                    else if (k == 1) put_rgb(c, 0, FONE, FONE - l);
                    else if (k == 2) put_rgb(c, l, FONE, 0);
                    else put_rgb(c, FONE, FONE - l, 0);
                end
                RAMP_BLUE_RED: put_rgb(c, f, 0, u);
                RAMP_GREY: put_rgb(c, f, f, f);
                RAMP_HUE: begin
                    k = seg_of(f, 6, l);
                    if (k == 0) put_rgb(c, FONE, l, 0);
                    else if (k == 1) put_rgb(c, FONE - l, FONE, 0);
                    else if (k == 2) put_rgb(c, 0, FONE, l);
                    else if (k == 3) put_rgb(c, 0, FONE - l, FONE);
                    else if (k == 4) put_rgb(c, l, 0, FONE);
                    else put_rgb(c, FONE, 0, FONE - l);
                end
                RAMP_GREEN_YELLOW: put_rgb(c, f, FONE, 0);
                RAMP_GREEN_MAGENTA: put_rgb(c, f, u, f);
                RAMP_WALK: begin
                    k = seg_of(f, 4, l);
                    if (k == 0) put_rgb(c, 0, l, FONE - l);
                    else if (k == 1) put_rgb(c, l, FONE - l, 0);
                    else if (k == 2) put_rgb(c, FONE - l, l, 0);
                    else put_rgb(c, 0, FONE - l, l);
                end
                RAMP_GREY_PEAK: begin
                    k = seg_of(f, 2, l);
                    if (k == 0) put_rgb(c, l, l, l);
                    else put_rgb(c, FONE - l, FONE - l, FONE - l);
                end
                RAMP_THREE_SEG: begin
                    k = seg_of(f, 3, l);
                    if (k == 0) put_rgb(c, FONE - l, 0, l);
                    else if (k == 1) put_rgb(c, 0, l, FONE);
                    else put_rgb(c, l, FONE - l, FONE);
                end
                RAMP_FIVE_SEG: begin
                    k = seg_of(f, 5, l);
                    if (k == 0) put_rgb(c, 0, l, FONE);
                    else if (k == 1) put_rgb(c, 0, FONE, FONE - l);
                    else if (k == 2) put_rgb(c, l, FONE, 0);
                    else if (k == 3) put_rgb(c, FONE, FONE - l, 0);
                    else put_rgb(c, FONE, l, l);
                end
                RAMP_BLEND_TWO: begin
                    longint a[3] = '{200, 60, 0};
                    longint b[3] = '{250, 160, 110};
                    for (int i = 0; i < 3; i++) begin
                        num[i] = a[i] * FONE + (b[i] - a[i]) * f;
                        den[i] = 255 * FONE;
                    end
                    mixed = 1;
                end
                RAMP_BLEND_A: begin
                    blend('{55, 55, 45}, '{200, 60, 0}, '{250, 160, 110}, 4, f, num, den);
                    mixed = 1;
                end
                RAMP_BLEND_B: begin
                    blend('{0, 255, 0}, '{255, 150, 0}, '{255, 250, 240}, 3, f, num, den);
                    mixed = 1;
                end
                RAMP_YELLOW_RED: put_rgb(c, FONE, u, 0);
                RAMP_TO_WHITE: begin
                    k = seg_of(f, 4, l);
                    if (k == 0) put_rgb(c, 0, l, FONE);
                    else if (k == 1) put_rgb(c, 0, FONE, FONE - l);
                    else if (k == 2) put_rgb(c, l, FONE, 0);
                    else put_rgb(c, FONE, FONE, l);
                end
                RAMP_TWO_A: begin
                    k = seg_of(f, 2, l);
                    if (k == 0) put_rgb(c, 0, l, FONE - l);
                    else put_rgb(c, l, FONE - l, 0);
                end
                RAMP_TWO_B: begin
                    k = seg_of(f, 2, l);
                    if (k == 0) put_rgb(c, FONE, FONE - l, l);
                    else put_rgb(c, FONE - l, l, FONE);
                end
                RAMP_BLUE_CYAN: put_rgb(c, 0, f, FONE);
                RAMP_BLUE_WHITE: put_rgb(c, f, f, FONE);
                RAMP_BLEND_C: begin
                    blend('{0, 160, 0}, '{180, 220, 0}, '{250, 220, 170}, 3, f, num, den);
                    mixed = 1;
                end
                default: ;
            endcase
            if (!mixed) begin
                for (int i = 0; i < 3; i++) begin
                    num[i] = c[i];
                    den[i] = FONE;
                end
            end
            res.red = to_chan(num[0], den[0]);
            res.green = to_chan(num[1], den[1]);
            res.blue = to_chan(num[2], den[2]);
            return res;
        endfunction

        function void note_sample(logic signed [15:0] smp);
            pending.push_back(map_sample(smp));
        endfunction

        function void check_color(t_color got);
            t_color want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected color %0d %0d %0d", $time,
                         got.red, got.green, got.blue);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.red !== want.red) begin
                $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
                errors++;
            end
            if (got.green !== want.green) begin
                $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue) begin
                $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_sample;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_wdata;

    color_scoreboard board;
    int  cycle_count;
    bit  hold_off_req;

    pseudocolor_ramp_mapper dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_sample(i_sample),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_red(o_red), .o_green(o_green), .o_blue(o_blue),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    initial begin
        board = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_sample = '0;
        i_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_RANGE_LOW;
        i_cfg_wdata = '0;
        hold_off_req = 0;
        cycle_count = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function int pick_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // Receiver: random stalls, plus one long hold-off when asked.
    initial begin
        int n;
        @(posedge i_clk);
        while (1) begin
            if (hold_off_req) begin
                i_stall <= 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off_req = 0;
            end
            n = pick_gap();
            if ($urandom_range(0, 3) == 0) n = 0;
            i_stall <= (n != 0);
            if (n != 0) begin
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_color('{red: o_red, green: o_green, blue: o_blue});
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_RANGE_LOW: board.lo_reg = val;
            CFG_RANGE_HIGH: board.hi_reg = val;
            default: board.sel_reg = val[4:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_sample(logic [15:0] smp, bit gaps);
        int n;
        n = gaps ? pick_gap() : 0;
        if (n != 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= smp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_sample(smp);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function logic [15:0] random_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return board.lo_reg + 16'($urandom_range(0, 3)) - 16'd1;
            3: return board.hi_reg + 16'($urandom_range(0, 3)) - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] edges[6];
        logic [15:0] lo, hi;
        edges = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h4000, 16'h2000};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, then every ramp including numbers above 20.
        foreach (edges[i]) send_sample(edges[i], 0);
        drain();
        write_reg(CFG_RANGE_LOW, 16'h8000);
        write_reg(CFG_RANGE_HIGH, 16'h7FFF);
        for (int s = 0; s < 32; s++) begin
            write_reg(CFG_RAMP_SELECT, 16'(s));
            send_sample(16'h8000, 0);
            send_sample(16'hB333, 0);
            send_sample(16'h7FFF, 0);
            drain();
        end
        // Empty and reversed ranges give a zero fraction.
        write_reg(CFG_RANGE_LOW, 16'd100);
        write_reg(CFG_RANGE_HIGH, 16'd100);
        send_sample(16'd500, 0);
        drain();
        write_reg(CFG_RANGE_HIGH, 16'hFF00);
        send_sample(16'd500, 0);
        drain();
        write_reg(CFG_RAMP_SELECT, 16'(RAMP_BLUE_RED));
        send_sample(16'd500, 0);
        drain();

        // Random phases with random settings; one phase stalls the receiver long.
        for (int p = 0; p < 30; p++) begin
            lo = 16'($urandom);
            hi = 16'($urandom);
            if (p % 10 == 1) begin lo = 16'h8000; hi = 16'h7FFF; end
            if (p % 10 == 2) begin lo = 16'hFFFE; hi = 16'hFFFF; end
            write_reg(CFG_RANGE_LOW, lo);
            write_reg(CFG_RANGE_HIGH, hi);
            write_reg(CFG_RAMP_SELECT, 16'($urandom_range(0, 31)));
            if (p == 5) hold_off_req = 1;
            for (int i = 0; i < 27; i++) send_sample(random_sample(), 1);
            drain();
        end
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
